FILE: rtl/scnt_pkg.sv
package scnt_pkg;

    // Widest operand the queue entry carries (largest operand width plus one)
    localparam int OPND_MAX = 33;

    // Selection modes
    localparam logic [2:0] MODE_COMB     = 3'd0;
    localparam logic [2:0] MODE_COMB_REP = 3'd1;
    localparam logic [2:0] MODE_VAR      = 3'd2;
    localparam logic [2:0] MODE_VAR_REP  = 3'd3;
    localparam logic [2:0] MODE_PERM     = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_K_GT_N   = 2'd1;
    localparam logic [1:0] ST_BAD_MODE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Kinds of work handed to the back end
    localparam logic [1:0] KIND_DIRECT  = 2'd0;
    localparam logic [1:0] KIND_BINOM   = 2'd1;
    localparam logic [1:0] KIND_FALLING = 2'd2;
    localparam logic [1:0] KIND_POWER   = 2'd3;

    // One classified item waiting for the back end
    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          status;
        logic                one_val;
        logic [OPND_MAX-1:0] base;
        logic [OPND_MAX-1:0] steps;
    } scnt_cmd_t;

endpackage

FILE: rtl/scnt_front.sv
module scnt_front #(
    parameter int OPERAND_BITS = 12
) (
    input  logic [2:0]              func,
    input  logic [OPERAND_BITS-1:0] n_items,
    input  logic [OPERAND_BITS-1:0] k_chosen,
    output scnt_pkg::scnt_cmd_t     cmd
);
    import scnt_pkg::*;

    localparam int MW = OPERAND_BITS + 1;

    logic [MW-1:0] n_w;
    logic [MW-1:0] k_w;
    logic [MW-1:0] n_minus_k;
    logic [MW-1:0] ks_comb;
    logic [MW-1:0] n_rep;
    logic [MW-1:0] n_less1;
    logic [MW-1:0] ks_rep;
    logic          k_gt_n;

    // Operand arithmetic shared by the modes
    assign n_w       = {1'b0, n_items};
    assign k_w       = {1'b0, k_chosen};
    assign k_gt_n    = k_w > n_w;
    assign n_minus_k = n_w - k_w;
    assign ks_comb   = (k_w > n_minus_k) ? n_minus_k : k_w;
    assign n_rep     = n_w + k_w - MW'(1);
    assign n_less1   = n_w - MW'(1);
    assign ks_rep    = (k_w > n_less1) ? n_less1 : k_w;

    // Classify the item into a direct answer or a loop for the back end
    always_comb
    begin
        cmd         = '0;
        cmd.kind    = KIND_DIRECT;
        cmd.status  = ST_OK;
        unique case (func)
            MODE_COMB:
            begin
                if (k_gt_n)
                    cmd.status = ST_K_GT_N;
                else
                begin
                    cmd.kind  = KIND_BINOM;
                    cmd.base  = OPND_MAX'(n_w - ks_comb);
                    cmd.steps = OPND_MAX'(ks_comb);
                end
            end
            MODE_COMB_REP:
            begin
                if (n_w == '0)
                    cmd.one_val = (k_w == '0);
                else
                begin
                    cmd.kind  = KIND_BINOM;
                    cmd.base  = OPND_MAX'(n_rep - ks_rep);
                    cmd.steps = OPND_MAX'(ks_rep);
                end
            end
            MODE_VAR:
            begin
                if (k_gt_n)
                    cmd.status = ST_K_GT_N;
                else
                begin
                    cmd.kind  = KIND_FALLING;
                    cmd.base  = OPND_MAX'(n_w);
                    cmd.steps = OPND_MAX'(k_w);
                end
            end
            MODE_VAR_REP:
            begin
                if (k_w == '0)
                    cmd.one_val = 1'b1;
                else if (n_w <= MW'(1))
                    cmd.one_val = n_w[0];
                else
                begin
                    cmd.kind  = KIND_POWER;
                    cmd.base  = OPND_MAX'(n_w);
                    cmd.steps = OPND_MAX'(k_w);
                end
            end
            MODE_PERM:
            begin
                cmd.kind  = KIND_FALLING;
                cmd.base  = OPND_MAX'(n_w);
                cmd.steps = OPND_MAX'(n_w);
            end
            default:
                cmd.status = ST_BAD_MODE;
        endcase
    end

endmodule

FILE: rtl/scnt_queue.sv
module scnt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scnt_pkg::scnt_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                nonempty,
    output scnt_pkg::scnt_cmd_t pop_cmd
);
    import scnt_pkg::*;

    localparam int DEPTH = 2;

    scnt_cmd_t mem_reg [DEPTH];
    logic      wr_ptr_reg;
    logic      wr_ptr_next;
    logic      rd_ptr_reg;
    logic      rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full     = (fill_reg == 2'(DEPTH));
    assign nonempty = (fill_reg != 2'd0);
    assign pop_cmd  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: rtl/scnt_back.sv
module scnt_back #(
    parameter int OPERAND_BITS = 12,
    parameter int COUNT_BITS   = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  scnt_pkg::scnt_cmd_t   cmd,
    output logic                  cmd_pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [COUNT_BITS-1:0] res_count,
    output logic [1:0]            res_status
);
    import scnt_pkg::*;

    localparam int MW = OPERAND_BITS + 1;
    localparam int PW = COUNT_BITS + MW;
    localparam int CW = $clog2(PW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            kind_reg, kind_next;
    logic [COUNT_BITS-1:0] r_reg, r_next;
    logic [PW-1:0]         acc_reg, acc_next;
    logic [MW-1:0]         mul_reg, mul_next;
    logic [MW-1:0]         fac_reg, fac_next;
    logic [MW-1:0]         div_reg, div_next;
    logic [MW-1:0]         left_reg, left_next;
    logic [MW:0]           rem_reg, rem_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] fin_cnt_reg, fin_cnt_next;
    logic [1:0]            fin_st_reg, fin_st_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0] out_cnt_reg, out_cnt_next;
    logic [1:0]            out_st_reg, out_st_next;
    logic [MW:0]           trial;
    logic                  fits;
    logic                  take_out;
    logic [MW-1:0]         base_w;
    logic [MW-1:0]         first_fac;
    logic [MW-1:0]         step_fac;

    assign res_valid  = out_valid_reg;
    assign res_count  = out_cnt_reg;
    assign res_status = out_st_reg;

    assign base_w    = cmd.base[MW-1:0];
    assign first_fac = (cmd.kind == KIND_BINOM) ? base_w + MW'(1) : base_w;
    assign trial     = {rem_reg[MW-1:0], acc_reg[PW-1]};
    assign fits      = (acc_reg[PW-1:COUNT_BITS] == '0);
    assign take_out  = !out_valid_reg || res_ready;

    // Next factor of the product walk
    always_comb
    begin
        case (kind_reg)
            KIND_BINOM:   step_fac = fac_reg + MW'(1);
            KIND_FALLING: step_fac = fac_reg - MW'(1);
            default:      step_fac = fac_reg;
        endcase
    end

    // Sequencer: shift-add multiply, restoring divide, range check
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        mul_next       = mul_reg;
        fac_next       = fac_reg;
        div_next       = div_reg;
        left_next      = left_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        fin_cnt_next   = fin_cnt_reg;
        fin_st_next    = fin_st_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_cnt_next   = out_cnt_reg;
        out_st_next    = out_st_reg;
        cmd_pop        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    kind_next = cmd.kind;
                    r_next    = COUNT_BITS'(1);
                    fac_next  = first_fac;
                    mul_next  = first_fac;
                    div_next  = MW'(1);
                    left_next = cmd.steps[MW-1:0];
                    acc_next  = '0;
                    cnt_next  = CW'(MW);
                    if (cmd.kind == KIND_DIRECT)
                    begin
                        fin_cnt_next = COUNT_BITS'(cmd.one_val);
                        fin_st_next  = cmd.status;
                        state_next   = S_FIN;
                    end
                    else if (cmd.steps[MW-1:0] == '0)
                    begin
                        fin_cnt_next = COUNT_BITS'(1);
                        fin_st_next  = ST_OK;
                        state_next   = S_FIN;
                    end
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next = {acc_reg[PW-2:0], 1'b0}
                         + (mul_reg[MW-1] ? PW'(r_reg) : PW'(0));
                mul_next = {mul_reg[MW-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (kind_reg == KIND_BINOM)
                    begin
                        rem_next   = '0;
                        cnt_next   = CW'(PW);
                        state_next = S_DIV;
                    end
                    else
                        state_next = S_CHK;
                end
            end
            S_DIV:
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = trial - {1'b0, div_reg};
                    acc_next = {acc_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    acc_next = {acc_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!fits)
                begin
                    fin_cnt_next = '0;
                    fin_st_next  = ST_OVERFLOW;
                    state_next   = S_FIN;
                end
                else if (left_reg == MW'(1))
                begin
                    fin_cnt_next = acc_reg[COUNT_BITS-1:0];
                    fin_st_next  = ST_OK;
                    state_next   = S_FIN;
                end
                else
                begin
                    r_next     = acc_reg[COUNT_BITS-1:0];
                    left_next  = left_reg - MW'(1);
                    fac_next   = step_fac;
                    mul_next   = step_fac;
                    div_next   = div_reg + MW'(1);
                    acc_next   = '0;
                    cnt_next   = CW'(MW);
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                if (take_out)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = fin_cnt_reg;
                    out_st_next    = fin_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        r_reg       <= r_next;
        acc_reg     <= acc_next;
        mul_reg     <= mul_next;
        fac_reg     <= fac_next;
        div_reg     <= div_next;
        left_reg    <= left_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        fin_cnt_reg <= fin_cnt_next;
        fin_st_reg  <= fin_st_next;
        out_cnt_reg <= out_cnt_next;
        out_st_reg  <= out_st_next;
    end

endmodule

FILE: rtl/selection_count_engine.sv
// Channel | Dir | tdata fields, lowest bit first
// s_axis  | in  | func[2:0], n_items, k_chosen, zero pad to bytes
// m_axis  | out | count, status[1:0], zero pad to bytes
//
// Errors and trivial cases pass through the queue and the S_FIN state before m_tvalid rises.
// Each loop step runs a multiply pass, plus a divide pass for binomials, plus a check;
// the back end uses a shift-add multiplier and a restoring divider. Loops stop on overflow.
// A loop item raises m_tvalid after the queue, its loop steps and the S_FIN state.
// Reset clears the queue, sequencer and output valid; no clearing pass.
// A 2-entry queue lets inputs be taken while the back end or output stalls.
module selection_count_engine #(
    parameter int OPERAND_BITS = 12,
    parameter int COUNT_BITS   = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func, n_items, k_chosen, zero pad
    input  logic [((3+2*OPERAND_BITS+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // count, status, zero pad
    output logic [((COUNT_BITS+2+7)/8)*8-1:0] m_tdata
);
    import scnt_pkg::*;

    localparam int OUT_W = ((COUNT_BITS + 2 + 7) / 8) * 8;

    scnt_cmd_t             front_cmd;
    scnt_cmd_t             q_cmd;
    logic                  q_full;
    logic                  q_nonempty;
    logic                  q_pop;
    logic [COUNT_BITS-1:0] res_count;
    logic [1:0]            res_status;

    assign s_tready = !q_full;

    // Classify incoming items
    scnt_front #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_front (
        .func     (s_tdata[2:0]),
        .n_items  (s_tdata[OPERAND_BITS+2:3]),
        .k_chosen (s_tdata[2*OPERAND_BITS+2:OPERAND_BITS+3]),
        .cmd      (front_cmd)
    );

    // Queue between front and back
    scnt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_tvalid && !q_full),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .pop_cmd  (q_cmd)
    );

    // Iterative arithmetic
    scnt_back #(
        .OPERAND_BITS(OPERAND_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_nonempty),
        .cmd        (q_cmd),
        .cmd_pop    (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_count  (res_count),
        .res_status (res_status)
    );

    assign m_tdata = OUT_W'({res_status, res_count});

endmodule

FILE: rtl/scnt_checker.sv
module scnt_checker #(
    parameter int OPERAND_BITS = 12,
    parameter int COUNT_BITS   = 64
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((COUNT_BITS+2+7)/8)*8-1:0]     m_tdata
);
    import scnt_pkg::*;

    logic [COUNT_BITS-1:0] out_count;
    logic [1:0]            out_status;
    logic                  in_take;

    assign out_count  = m_tdata[COUNT_BITS-1:0];
    assign out_status = m_tdata[COUNT_BITS+1:COUNT_BITS];
    assign in_take    = s_tvalid && s_tready;

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Any failing status carries a zero count
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status != ST_OK) |-> (out_count == '0))
        else $error("non-zero count with failing status");

    // The input only closes right after an item was taken
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(in_take))
        else $error("input closed without an item taken");

endmodule

bind selection_count_engine scnt_checker #(
    .OPERAND_BITS(OPERAND_BITS),
    .COUNT_BITS  (COUNT_BITS)
) u_scnt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
